// File: design/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } sha_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } sha_core_ctl_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] r;
        case (t)
            6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
            6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
            6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
            6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
            6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
            6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
            6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
            6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
            6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
            6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
            6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

// File: design/sha_round_unit.sv
module sha_round_unit
    import sha_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [511:0]  block,
    input  logic [255:0]  chain_in,
    output logic [255:0]  state_out,
    output sha_core_ctl_t ctl
);

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [5:0]  t_reg, t_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] wt, s0, s1, b0, b1, ch, maj, t1, t2, w15, w2;

    always_comb
    begin
        w2  = w_reg[14];
        w15 = w_reg[1];
        s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        wt = w_reg[0];
        b1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
           ^ {v_reg[4][24:0], v_reg[4][31:25]};
        b0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
           ^ {v_reg[0][21:0], v_reg[0][31:22]};
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + b1 + ch + round_k(t_reg) + wt;
        t2 = b0 + maj;
        busy_next = busy_reg;
        done_next = 1'b0;
        t_next = t_reg;
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v_next[i] = v_reg[i];
        end
        if (start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = chain_in[255 - 32*i -: 32];
            end
            t_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // window shifts: slot 0 is w[t]
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = s1 + w_reg[9] + s0 + w_reg[0];
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            t_next = t_reg + 6'd1;
            if (t_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
        t_reg <= t_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            state_out[255 - 32*i -: 32] = v_reg[i];
        end
        ctl.start = start;
        ctl.busy  = busy_reg;
        ctl.done  = done_reg;
    end

endmodule

// File: design/sha256_message_hasher.sv
// SHA-256 message hasher.
// Input channel (in_valid/in_ready, payload sha_in_t): one transfer carries an
// optional message byte and an end-of-message flag. A transfer with
// end_of_message set closes the message (an empty message is allowed).
// Output channel (out_valid/out_ready, payload sha_out_t): eight digest
// words, index 0 first, last_word set on index 7.
// Throughput: bytes that do not fill the block are taken one per cycle. A byte
// completing a 64-byte block holds in_ready low while the shared round unit
// loads the block, runs 64 rounds and signals done, and the result is folded.
// Closing a message runs padding one byte per cycle, places the length,
// runs one or two blocks, then emits 8 words, one per accepted output
// transfer; the first word is valid the cycle after the fold.
// The output register holds its word while out_ready is low; the sequencer
// waits, and no input is taken until the last word is transferred.
// Reset (rst_n low, async) loads the initial hash value and clears the fill
// count and bit length; after each digest they are reloaded the same way.
module sha256_message_hasher
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sha_out_t out_data
);

    sha_state_t    state_reg, state_next;
    sha_state_t    state_sel;
    logic [31:0]   chain_reg [8];
    logic [31:0]   chain_next [8];
    logic [31:0]   buf_reg [16];
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   len_reg, len_next;
    logic          closing_reg, closing_next;
    logic          final_blk_reg, final_blk_next;
    logic          len_done_reg, len_done_next;
    logic [2:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          wr_en;
    logic [7:0]    wr_byte;
    logic          start_reg, start_next;
    logic [511:0]  block;
    logic [255:0]  chain_flat, state_out;
    sha_core_ctl_t ctl;
    logic          in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            block[511 - 32*i -: 32] = buf_reg[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            chain_flat[255 - 32*i -: 32] = chain_reg[i];
        end
    end

    sha_round_unit u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .block     (block),
        .chain_in  (chain_flat),
        .state_out (state_out),
        .ctl       (ctl)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.byte_valid && fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (in_data.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                    state_next = ST_ROUND;
                else if (fill_reg == 6'd55)
                    state_next = ST_LEN;
                else
                    state_next = ST_PAD;
            end
            ST_LEN:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (ctl.done)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (!closing_reg)
                    state_next = ST_IDLE;
                else if (fill_reg == 6'd0 && len_reg != 64'd0 && 1'b0)
                    state_next = ST_PAD;
                else
                    state_next = ST_FOLD;
            end
            ST_EMIT:
            begin
                if (out_fire && idx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        fill_next      = fill_reg;
        len_next       = len_reg;
        closing_next   = closing_reg;
        final_blk_next = final_blk_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        wr_en      = 1'b0;
        wr_byte    = in_data.data_byte;
        start_next = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    closing_next = in_data.end_of_message;
                    final_blk_next = 1'b0;
                    if (in_data.byte_valid)
                    begin
                        wr_en = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        len_next = len_reg + 64'd8;
                        start_next = (fill_reg == 6'd63);
                    end
                end
            end
            ST_PAD:
            begin
                wr_en = 1'b1;
                wr_byte = (closing_reg && !final_blk_reg) ? 8'h00 : 8'h00;
                if (!final_blk_reg)
                    wr_byte = PAD_BYTE;
                final_blk_next = 1'b1;
                fill_next = fill_reg + 6'd1;
                start_next = (fill_reg == 6'd63);
            end
            ST_LEN:
            begin
                start_next = 1'b1;
                fill_next = '0;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + state_out[255 - 32*i -: 32];
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        out_valid_next = 1'b0;
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_next[i] = init_hash(3'(i));
                        end
                        fill_next = '0;
                        len_next = '0;
                        closing_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // fold step resolves: more padding, emit, or back to idle
    always_comb
    begin
        state_sel = state_next;
        if (state_reg == ST_FOLD)
        begin
            if (!closing_reg)
                state_sel = ST_IDLE;
            else if (!final_blk_reg)
                state_sel = ST_PAD;
            else if (fill_reg == 6'd0 && !len_done_reg)
                state_sel = ST_PAD;
            else
                state_sel = ST_EMIT;
        end
    end

    // length written into buffer tail in ST_LEN; flag set there, cleared in ST_IDLE
    always_comb
    begin
        len_done_next = len_done_reg;
        if (state_reg == ST_LEN)
            len_done_next = 1'b1;
        else if (state_reg == ST_IDLE)
            len_done_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= wr_byte;
        if (state_reg == ST_LEN)
        begin
            buf_reg[14] <= len_reg[63:32];
            buf_reg[15] <= len_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            closing_reg   <= 1'b0;
            final_blk_reg <= 1'b0;
            len_done_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_sel;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            closing_reg   <= closing_next;
            final_blk_reg <= final_blk_next;
            len_done_reg  <= len_done_next;
            start_reg     <= start_next;
            idx_reg       <= (state_sel == ST_EMIT && state_reg != ST_EMIT) ? 3'd0 : idx_next;
            out_valid_reg <= (state_sel == ST_EMIT && state_reg != ST_EMIT) ? 1'b1
                                                                            : out_valid_next;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_comb
    begin
        out_data.digest_word = chain_reg[idx_reg];
        out_data.word_index  = idx_reg;
        out_data.last_word   = (idx_reg == 3'd7);
    end

endmodule

// File: verif/tb_sha256_message_hasher.sv
`timescale 1ns / 100ps

module tb_sha256_message_hasher;
    import sha_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 410;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HINIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        sha_in_t     item;
        bit          known;
        logic [31:0] word0;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    sha_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    sha_out_t out_data;

    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int          block_fill;
    logic [63:0] msg_bits;

    sha_out_t digest_q [$];
    int  mismatches;
    int  idle_cycles;
    int  inputs_sent;
    int  words_checked;
    int  digests_done;
    int  fast_out;
    bit  in_xfer;
    bit  out_xfer;

    sha256_message_hasher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    function automatic void absorb(input logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64)
        begin
            compress();
            block_fill = 0;
        end
    endfunction

    function automatic void hasher_restart();
        for (int i = 0; i < 8; i++)
            hash_state[i] = HINIT[i];
        block_fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void predict_digest(input sha_in_t it, input bit known,
                                           input logic [31:0] word0);
        sha_out_t o;
        if (it.byte_valid)
        begin
            absorb(it.data_byte);
            msg_bits += 64'd8;
        end
        if (!it.end_of_message)
            return;
        absorb(PAD_BYTE);
        while (block_fill != 56)
            absorb(8'h00);
        for (int i = 0; i < 8; i++)
            block_bytes[56+i] = msg_bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            o.digest_word = (known && i == 0) ? word0 : hash_state[i];
            o.word_index = 3'(i);
            o.last_word = (i == 7);
            digest_q.push_back(o);
        end
        hasher_restart();
    endfunction

    task automatic send_item(input sha_in_t it, input int gap, input bit known = 0,
                             input logic [31:0] word0 = '0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        predict_digest(it, known, word0);
        inputs_sent++;
    endtask

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic sha_in_t mk(input logic [7:0] d, input logic bv, input logic eom);
        sha_in_t it;
        it.data_byte = d;
        it.byte_valid = bv;
        it.end_of_message = eom;
        return it;
    endfunction

    // output side
    initial
    begin
        int stall;
        sha_out_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                fast_out = $urandom_range(0, 1);
            stall = fast_out ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            words_checked++;
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: word %h idx %0d last %0b",
                             out_data.digest_word, out_data.word_index, out_data.last_word);
            end
            else
            begin
                want = digest_q.pop_front();
                if (want.last_word)
                    digests_done++;
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp word %h idx %0d last %0b, got %h idx %0d last %0b",
                                 want.digest_word, want.word_index, want.last_word,
                                 out_data.digest_word, out_data.word_index, out_data.last_word);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        in_xfer = in_valid && in_ready;
        out_xfer = out_valid && out_ready;
        if (!rst_n || in_xfer || out_xfer)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        int len;
        int pick;
        int drained;
        bit burst;
        sha_in_t it;

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        inputs_sent = 0;
        words_checked = 0;
        digests_done = 0;
        fast_out = 0;
        hasher_restart();
        for (int i = 0; i < 64; i++)
            block_bytes[i] = '0;

        dir_rows = '{
            '{mk(8'h00, 1'b0, 1'b0), 1'b0, 32'h0},
            '{mk(8'hff, 1'b0, 1'b0), 1'b0, 32'h0},
            '{mk(8'h00, 1'b0, 1'b1), 1'b1, 32'he3b0c442},
            '{mk(8'h61, 1'b1, 1'b0), 1'b0, 32'h0},
            '{mk(8'h62, 1'b1, 1'b0), 1'b0, 32'h0},
            '{mk(8'hee, 1'b0, 1'b0), 1'b0, 32'h0},
            '{mk(8'h63, 1'b1, 1'b1), 1'b1, 32'hba7816bf},
            '{mk(8'hff, 1'b0, 1'b1), 1'b1, 32'he3b0c442},
            '{mk(8'h00, 1'b1, 1'b1), 1'b0, 32'h0},
            '{mk(8'hff, 1'b1, 1'b1), 1'b0, 32'h0},
            '{mk(8'h61, 1'b1, 1'b0), 1'b0, 32'h0},
            '{mk(8'h62, 1'b1, 1'b0), 1'b0, 32'h0},
            '{mk(8'h63, 1'b1, 1'b0), 1'b0, 32'h0},
            '{mk(8'h55, 1'b0, 1'b1), 1'b1, 32'hba7816bf},
            '{mk(8'haa, 1'b1, 1'b0), 1'b0, 32'h0},
            '{mk(8'h00, 1'b0, 1'b1), 1'b0, 32'h0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, draw_gap(1'($urandom_range(0, 1))),
                      dir_rows[i].known, dir_rows[i].word0);

        // random messages: mostly short, some lengths around the padding boundaries
        while (inputs_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 20);
                6, 7: len = $urandom_range(52, 68);
                8: len = $urandom_range(115, 129);
                default: len = $urandom_range(0, 2);
            endcase
            if (len > RANDOM_ITEMS - inputs_sent)
                len = RANDOM_ITEMS - inputs_sent;
            burst = ($urandom_range(0, 3) == 0);
            for (int b = 0; b < len; b++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(mk(8'($urandom), 1'b0, 1'b0), draw_gap(burst));
                it = mk(8'($urandom), 1'b1, (b == len - 1) && $urandom_range(0, 1));
                send_item(it, draw_gap(burst));
                if (it.end_of_message)
                    break;
            end
            if (!it.end_of_message || len == 0)
                send_item(mk(8'($urandom), 1'b0, 1'b1), draw_gap(burst));
            it = '0;
        end
        in_valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        drained = 0;
        while (drained < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drained++;
        end

        $display("covered %0d input transfers, %0d digests, %0d output words",
                 inputs_sent, digests_done, words_checked);
        $display("message lengths spanned empty through multi-block, with padding wrap");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
